// ===== hw/rtl/lmfs_pkg.sv =====
// Package for the LED mask frame sender: command and status codes, frame bytes,
// configuration defaults and the descriptor passed from front to back.
// No dependencies.
package lmfs_pkg;

    localparam int unsigned DescDepth = 4;

    localparam logic [7:0]  FRAME_HEAD = 8'h94;
    localparam logic [7:0]  ACK_BYTE   = 8'h81;
    localparam logic [7:0]  NAK_BYTE   = 8'h80;
    localparam logic [31:0] ALL_ON     = 32'hFFFF_FFFF;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [3:0]  ATTEMPTS_RESET = 4'd5;

    localparam int unsigned FRAME_BEATS = 5;
    localparam logic [2:0]  LAST_BEAT   = 3'(FRAME_BEATS - 1);

    typedef enum logic [2:0] {
        CMD_SET_ONE = 3'd0,
        CMD_SET_ALL = 3'd1,
        CMD_UPDATE  = 3'd2,
        CMD_RX_BYTE = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_BUSY      = 3'd2,
        ST_ACKED     = 3'd3,
        ST_GAVE_UP   = 3'd4,
        ST_RESENDING = 3'd5
    } t_status;

    typedef enum logic {
        CFG_TIMEOUT  = 1'b0,
        CFG_ATTEMPTS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        frame;
        t_status     status;
        logic [31:0] mask;
    } t_desc;

endpackage

// ===== hw/rtl/lmfs_front.sv =====
// Front part: holds the LED mask, the retry state and the configuration registers,
// and turns each accepted item into one descriptor. Depends on lmfs_pkg.
module lmfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_command,
    input  logic [5:0]        i_led_index,
    input  logic              i_led_on,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output lmfs_pkg::t_desc   o_desc
);

    logic [15:0] r_timeout;
    logic [3:0]  r_max;
    logic [31:0] r_mask,  n_mask;
    logic        r_await, n_await;
    logic [3:0]  r_att,   n_att;
    logic [15:0] r_timer, n_timer;
    logic [15:0] timer_inc;
    logic        do_retry;

    assign timer_inc = r_timer + 16'd1;

    always_comb begin
        n_mask        = r_mask;
        n_await       = r_await;
        n_att         = r_att;
        n_timer       = r_timer;
        do_retry      = 1'b0;
        o_desc.frame  = 1'b0;
        o_desc.status = lmfs_pkg::ST_OK;
        unique case (lmfs_pkg::t_cmd'(i_command))
            lmfs_pkg::CMD_SET_ONE: begin
                if (i_led_index[5]) begin
                    o_desc.status = lmfs_pkg::ST_BAD_INDEX;
                end else begin
                    n_mask[~i_led_index[4:0]] = i_led_on;
                end
            end
            lmfs_pkg::CMD_SET_ALL: begin
                n_mask = i_led_on ? lmfs_pkg::ALL_ON : '0;
            end
            lmfs_pkg::CMD_UPDATE: begin
                if (r_await) begin
                    o_desc.status = lmfs_pkg::ST_BUSY;
                end else begin
                    n_await      = 1'b1;
                    n_att        = 4'd1;
                    n_timer      = '0;
                    o_desc.frame = 1'b1;
                end
            end
            lmfs_pkg::CMD_RX_BYTE: begin
                if (r_await) begin
                    if (i_rx_byte == lmfs_pkg::ACK_BYTE) begin
                        n_await       = 1'b0;
                        n_timer       = '0;
                        o_desc.status = lmfs_pkg::ST_ACKED;
                    end else if (i_rx_byte == lmfs_pkg::NAK_BYTE) begin
                        do_retry = 1'b1;
                    end
                end
            end
            lmfs_pkg::CMD_TICK: begin
                if (r_await) begin
                    n_timer = timer_inc;
                    if (timer_inc >= r_timeout) begin
                        do_retry = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (do_retry) begin
            n_timer = '0;
            if (r_att < r_max) begin
                n_att         = r_att + 4'd1;
                o_desc.frame  = 1'b1;
                o_desc.status = lmfs_pkg::ST_RESENDING;
            end else begin
                n_await       = 1'b0;
                o_desc.status = lmfs_pkg::ST_GAVE_UP;
            end
        end
        o_desc.mask = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= lmfs_pkg::TIMEOUT_RESET;
            r_max     <= lmfs_pkg::ATTEMPTS_RESET;
            r_mask    <= '0;
            r_await   <= 1'b0;
            r_att     <= '0;
            r_timer   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (lmfs_pkg::t_cfg_idx'(i_cfg_idx))
                    lmfs_pkg::CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                    lmfs_pkg::CFG_ATTEMPTS: r_max     <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_mask  <= n_mask;
                r_await <= n_await;
                r_att   <= n_att;
                r_timer <= n_timer;
            end
        end
    end

    // While waiting for an acknowledge at least one frame has gone out.
    a_await_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_att != 4'd0))
        else $error("waiting with no attempt counted");

endmodule

// ===== hw/rtl/lmfs_fifo.sv =====
// Descriptor queue between the front and back parts, show-ahead read.
// Depends on lmfs_pkg.
module lmfs_fifo #(
    parameter int unsigned DEPTH = lmfs_pkg::DescDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  lmfs_pkg::t_desc i_data,
    input  logic            i_rd,
    output lmfs_pkg::t_desc o_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lmfs_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("descriptor queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("descriptor queue read while empty");

endmodule

// ===== hw/rtl/lmfs_back.sv =====
// Back part: expands each descriptor into one status beat or five frame beats
// and holds the current result beat in an output register. Depends on lmfs_pkg.
module lmfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmfs_pkg::t_desc i_desc,
    input  logic            i_desc_empty,
    output logic            o_desc_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_last,
    output logic [2:0]      o_status,
    output logic [31:0]     o_mask_now
);

    logic        r_out_valid;
    logic [2:0]  r_idx, n_idx;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_last;
    logic [2:0]  r_status;
    logic [31:0] r_mask;
    logic        slot_free;
    logic        fire;
    logic        beat_last;
    logic [7:0]  beat_byte;

    assign slot_free = !r_out_valid || i_pop;
    assign fire      = slot_free && !i_desc_empty;
    assign beat_last = !i_desc.frame || (r_idx == lmfs_pkg::LAST_BEAT);
    assign o_desc_rd = fire && beat_last;
    assign n_idx     = beat_last ? '0 : r_idx + 3'd1;

    always_comb begin
        case (r_idx)
            3'd0:    beat_byte = lmfs_pkg::FRAME_HEAD;
            3'd1:    beat_byte = i_desc.mask[31:24];
            3'd2:    beat_byte = i_desc.mask[23:16];
            3'd3:    beat_byte = i_desc.mask[15:8];
            default: beat_byte = i_desc.mask[7:0];
        endcase
        if (!i_desc.frame) begin
            beat_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tx_valid <= i_desc.frame;
            r_tx_byte  <= beat_byte;
            r_last     <= beat_last;
            r_status   <= i_desc.status;
            r_mask     <= i_desc.mask;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_tx_valid = r_tx_valid;
    assign o_tx_byte  = r_tx_byte;
    assign o_last     = r_last;
    assign o_status   = r_status;
    assign o_mask_now = r_mask;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= lmfs_pkg::LAST_BEAT)
        else $error("frame beat index out of range");

    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> (!i_desc_empty && i_desc.frame))
        else $error("frame in progress without a frame descriptor");

endmodule

// ===== hw/rtl/led_mask_frame_sender_with_retry_core.sv =====
// Top level of the LED mask frame sender with retry.
// Depends on lmfs_pkg, lmfs_front, lmfs_fifo and lmfs_back.
//
// Channel   Direction  Handshake             Payload
// input     in         push / full           i_command, i_led_index, i_led_on, i_rx_byte
// result    out        empty / pop           o_tx_valid, o_tx_byte, o_last, o_status,
//                                            o_mask_now
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// An item is taken every cycle while the descriptor queue has room; the front updates
// the mask and retry state in the same cycle. The back emits one beat per cycle while
// the result register is free or popped, so a frame item occupies it for five beats and
// any other item for one. An item's first beat passes the descriptor queue and then the
// output register. A stalled result side fills the descriptor queue (DESC_DEPTH entries)
// before full rises. Reset is synchronous and restores timeout 2000 and attempt limit 5.
module led_mask_frame_sender_with_retry_core #(
    parameter int unsigned DESC_DEPTH = lmfs_pkg::DescDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_led_index,
    input  logic        i_led_on,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [31:0] o_mask_now,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    lmfs_pkg::t_desc front_desc;
    lmfs_pkg::t_desc head_desc;
    logic            accept;
    logic            desc_empty;
    logic            desc_rd;

    assign accept = push && !full;

    lmfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_led_index (i_led_index),
        .i_led_on    (i_led_on),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_desc      (front_desc)
    );

    lmfs_fifo #(
        .DEPTH (DESC_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (front_desc),
        .i_rd    (desc_rd),
        .o_data  (head_desc),
        .o_full  (full),
        .o_empty (desc_empty)
    );

    lmfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (head_desc),
        .i_desc_empty (desc_empty),
        .o_desc_rd    (desc_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_mask_now   (o_mask_now)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_mask_frame_sender_with_retry_core.
// Depends on lmfs_pkg; a shadow of the LED mask and retry state predicts every result beat.
module testbench;

    localparam int unsigned LED_TOP       = 31;
    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 80;

    typedef struct {
        logic [2:0] cmd;
        logic [5:0] idx;
        logic       lit;
        logic [7:0] rx;
    } t_led_cmd;

    typedef struct {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              last;
        lmfs_pkg::t_status status;
        logic [31:0]       mask;
    } t_led_beat;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [2:0]  i_command   = '0;
    logic [5:0]  i_led_index = '0;
    logic        i_led_on    = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        empty;
    logic        pop         = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic [2:0]  o_status;
    logic [31:0] o_mask_now;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = 1'b0;
    logic [15:0] i_cfg_data  = '0;

    t_led_cmd  pending_cmds[$];
    t_led_beat expected_beats[$];

    logic [31:0] shadow_mask      = '0;
    logic        shadow_waiting   = 1'b0;
    logic [3:0]  shadow_tries     = '0;
    logic [15:0] shadow_timer     = '0;
    logic [15:0] shadow_timeout   = lmfs_pkg::TIMEOUT_RESET;
    logic [3:0]  shadow_max_tries = lmfs_pkg::ATTEMPTS_RESET;

    int unsigned error_count  = 0;
    int unsigned idle_cycles  = 0;
    int unsigned gap_max      = 0;
    int unsigned stall_max    = 0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_asks    = 0;
    int unsigned holds_served = 0;

    led_mask_frame_sender_with_retry_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_command   (i_command),
        .i_led_index (i_led_index),
        .i_led_on    (i_led_on),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last),
        .o_status    (o_status),
        .o_mask_now  (o_mask_now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void queue_reply(lmfs_pkg::t_status st);
        expected_beats.push_back('{1'b0, 8'h00, 1'b1, st, shadow_mask});
    endfunction

    function automatic void queue_frame(lmfs_pkg::t_status st);
        expected_beats.push_back('{1'b1, lmfs_pkg::FRAME_HEAD, 1'b0, st, shadow_mask});
        for (int k = 3; k >= 0; k--) begin
            expected_beats.push_back('{1'b1, shadow_mask[8*k +: 8], k == 0, st, shadow_mask});
        end
    endfunction

    function automatic void resend_or_give_up();
        shadow_timer = '0;
        if (shadow_tries < shadow_max_tries) begin
            shadow_tries = shadow_tries + 4'd1;
            queue_frame(lmfs_pkg::ST_RESENDING);
        end else begin
            shadow_waiting = 1'b0;
            queue_reply(lmfs_pkg::ST_GAVE_UP);
        end
    endfunction

    function automatic void predict_led_link(t_led_cmd c);
        case (c.cmd)
            lmfs_pkg::CMD_SET_ONE: begin
                if (c.idx > LED_TOP) begin
                    queue_reply(lmfs_pkg::ST_BAD_INDEX);
                end else begin
                    shadow_mask[LED_TOP - c.idx] = c.lit;
                    queue_reply(lmfs_pkg::ST_OK);
                end
            end
            lmfs_pkg::CMD_SET_ALL: begin
                shadow_mask = c.lit ? lmfs_pkg::ALL_ON : '0;
                queue_reply(lmfs_pkg::ST_OK);
            end
            lmfs_pkg::CMD_UPDATE: begin
                if (shadow_waiting) begin
                    queue_reply(lmfs_pkg::ST_BUSY);
                end else begin
                    shadow_waiting = 1'b1;
                    shadow_tries   = 4'd1;
                    shadow_timer   = '0;
                    queue_frame(lmfs_pkg::ST_OK);
                end
            end
            lmfs_pkg::CMD_RX_BYTE: begin
                if (!shadow_waiting) begin
                    queue_reply(lmfs_pkg::ST_OK);
                end else if (c.rx == lmfs_pkg::ACK_BYTE) begin
                    shadow_waiting = 1'b0;
                    shadow_timer   = '0;
                    queue_reply(lmfs_pkg::ST_ACKED);
                end else if (c.rx == lmfs_pkg::NAK_BYTE) begin
                    resend_or_give_up();
                end else begin
                    queue_reply(lmfs_pkg::ST_OK);
                end
            end
            lmfs_pkg::CMD_TICK: begin
                if (!shadow_waiting) begin
                    queue_reply(lmfs_pkg::ST_OK);
                end else begin
                    shadow_timer = shadow_timer + 16'd1;
                    if (shadow_timer >= shadow_timeout) begin
                        resend_or_give_up();
                    end else begin
                        queue_reply(lmfs_pkg::ST_OK);
                    end
                end
            end
            default: begin
                queue_reply(lmfs_pkg::ST_OK);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : sender
        logic go;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_led_link(pending_cmds.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0 && gap_max > 0) begin
                    gap_left   = $urandom_range(0, gap_max);
                    burst_left = $urandom_range(1, 24);
                end
            end
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() > 0) begin
                go = 1'b1;
            end
            push <= go;
            if (go) begin
                i_command   <= pending_cmds[0].cmd;
                i_led_index <= pending_cmds[0].idx;
                i_led_on    <= pending_cmds[0].lit;
                i_rx_byte   <= pending_cmds[0].rx;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        t_led_beat want;
        logic      take;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing, %s %h %h %0d %h",
                             $time, "actual", o_tx_valid, o_tx_byte, o_status,
                             o_mask_now);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("tx_valid", want.tx_valid, o_tx_valid);
                    check_field("tx_byte", want.tx_byte, o_tx_byte);
                    check_field("last", want.last, o_last);
                    check_field("status", want.status, o_status);
                    check_field("mask_now", want.mask, o_mask_now);
                end
            end
            take = 1'b1;
            if (holds_served != hold_asks) begin
                holds_served = hold_asks;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (stall_max > 0 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, stall_max - 1);
                take       = 1'b0;
            end
            pop <= take;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_cmd(logic [2:0] cmd, logic [5:0] idx, logic lit, logic [7:0] rx);
        pending_cmds.push_back('{cmd, idx, lit, rx});
    endtask

    task automatic add_random(logic [2:0] cmd);
        add_cmd(cmd, $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    task automatic add_led(logic [5:0] idx);
        add_cmd(lmfs_pkg::CMD_SET_ONE, idx, $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    task automatic add_rx(logic [7:0] rx);
        add_cmd(lmfs_pkg::CMD_RX_BYTE, $urandom_range(0, 63), $urandom_range(0, 1), rx);
    endtask

    task automatic set_regs(logic [15:0] ticks, logic [3:0] tries);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= lmfs_pkg::CFG_TIMEOUT;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        i_cfg_idx  <= lmfs_pkg::CFG_ATTEMPTS;
        i_cfg_data <= {12'($urandom), tries};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_timeout   = ticks;
        shadow_max_tries = tries;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly complete exchanges: an update, then ticks, retries, stray bytes and
    // mask edits, usually closed by an acknowledge. The rest are mask edits and noise.
    task automatic queue_traffic(int unsigned target);
        int unsigned added;
        int unsigned kind;
        int unsigned n;
        added = 0;
        while (added < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_random(lmfs_pkg::CMD_SET_ALL);
                    end else if ($urandom_range(0, 7) == 0) begin
                        add_led($urandom_range(LED_TOP + 1, 63));
                    end else begin
                        add_led($urandom_range(0, LED_TOP));
                    end
                end
                added += n;
            end else if (kind < 9) begin
                add_random(lmfs_pkg::CMD_UPDATE);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: add_random(lmfs_pkg::CMD_TICK);
                        5, 6:          add_rx(lmfs_pkg::NAK_BYTE);
                        7:             add_random(lmfs_pkg::CMD_RX_BYTE);
                        8:             add_led($urandom_range(0, LED_TOP));
                        default:       add_random(lmfs_pkg::CMD_UPDATE);
                    endcase
                end
                added += n + 1;
                if ($urandom_range(0, 3) != 0) begin
                    add_rx(lmfs_pkg::ACK_BYTE);
                    added++;
                end
            end else begin
                add_random($urandom_range(0, 7));
                added++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_max   = 3;
        stall_max = 2;
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd0, 1'b1, 8'h00);
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd31, 1'b1, 8'hFF);
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd32, 1'b1, 8'h00);
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd63, 1'b0, 8'hFF);
        add_cmd(lmfs_pkg::CMD_SET_ALL, 6'd63, 1'b1, 8'h00);
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd5, 1'b0, 8'h00);
        add_cmd(lmfs_pkg::CMD_UPDATE, 6'd0, 1'b0, 8'h00);
        add_cmd(lmfs_pkg::CMD_UPDATE, 6'd0, 1'b1, 8'hFF);
        add_cmd(lmfs_pkg::CMD_RX_BYTE, 6'd0, 1'b0, 8'h55);
        add_cmd(lmfs_pkg::CMD_SET_ONE, 6'd7, 1'b0, 8'h00);
        add_cmd(lmfs_pkg::CMD_RX_BYTE, 6'd0, 1'b0, lmfs_pkg::NAK_BYTE);
        add_cmd(lmfs_pkg::CMD_TICK, 6'd0, 1'b0, 8'h00);
        add_cmd(lmfs_pkg::CMD_RX_BYTE, 6'd0, 1'b0, lmfs_pkg::ACK_BYTE);
        add_cmd(lmfs_pkg::CMD_RX_BYTE, 6'd0, 1'b0, lmfs_pkg::ACK_BYTE);
        add_cmd(lmfs_pkg::CMD_TICK, 6'd63, 1'b1, 8'hFF);
        add_cmd(3'(lmfs_pkg::CMD_TICK) + 3'd1, 6'd0, 1'b0, 8'h00);
        add_cmd(3'd7, 6'd63, 1'b1, 8'hFF);
        add_cmd(lmfs_pkg::CMD_SET_ALL, 6'd0, 1'b0, 8'h00);
        add_cmd(lmfs_pkg::CMD_UPDATE, 6'd0, 1'b0, 8'h00);
        repeat (5) add_cmd(lmfs_pkg::CMD_RX_BYTE, 6'd0, 1'b0, lmfs_pkg::NAK_BYTE);
        drain();

        set_regs(16'd4, 4'd3);
        gap_max   = 4;
        stall_max = 4;
        queue_traffic(100);
        drain();

        set_regs(16'd1, 4'd1);
        gap_max   = 0;
        stall_max = 0;
        queue_traffic(70);
        drain();

        set_regs(16'd0, 4'd0);
        gap_max   = 2;
        stall_max = 3;
        add_random(lmfs_pkg::CMD_UPDATE);
        add_random(lmfs_pkg::CMD_TICK);
        add_random(lmfs_pkg::CMD_UPDATE);
        add_rx(lmfs_pkg::NAK_BYTE);
        add_random(lmfs_pkg::CMD_UPDATE);
        add_rx(lmfs_pkg::ACK_BYTE);
        queue_traffic(30);
        drain();

        set_regs(16'd65535, 4'd15);
        gap_max   = 5;
        stall_max = 5;
        queue_traffic(70);
        drain();

        // The receiver holds off while the sender keeps offering, so the block fills.
        set_regs(16'd3, 4'd5);
        gap_max   = 0;
        stall_max = 2;
        queue_traffic(70);
        @(posedge i_clk);
        hold_asks <= hold_asks + 1;
        drain();

        set_regs(16'd7, 4'd2);
        gap_max   = 6;
        stall_max = 8;
        queue_traffic(110);
        drain();

        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
